// ===== hw/rtl/bql_pkg.sv =====
// Shared types, token codes and character constants for the boolean query lexer.
// No dependencies; every other file imports this package.
package bql_pkg;

    localparam int MAX_QUERY_LEN = 4096;
    localparam int POS_W         = 12;
    localparam int POS_LIMIT     = (MAX_QUERY_LEN > 4096) ? 4096 : MAX_QUERY_LEN;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [3:0] KIND_TERM    = 4'd0;
    localparam logic [3:0] KIND_PHRASE  = 4'd1;
    localparam logic [3:0] KIND_AND     = 4'd2;
    localparam logic [3:0] KIND_OR      = 4'd3;
    localparam logic [3:0] KIND_NOT     = 4'd4;
    localparam logic [3:0] KIND_LPAREN  = 4'd5;
    localparam logic [3:0] KIND_RPAREN  = 4'd6;
    localparam logic [3:0] KIND_END     = 4'd7;
    localparam logic [3:0] KIND_UNTERM  = 4'd8;
    localparam logic [3:0] KIND_TOOLONG = 4'd9;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_WORD   = 2'd1;
    localparam logic [1:0] MODE_PHRASE = 2'd2;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [23:0] WORD_AND = 24'h414E44;
    localparam logic [23:0] WORD_OR  = 24'h004F52;
    localparam logic [23:0] WORD_NOT = 24'h4E4F54;

    typedef struct packed {
        logic [3:0]       kind;
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] length;
    } t_token;

    // All tokens caused by one input byte, oldest in slot 0
    typedef struct packed {
        logic [1:0]   cnt;
        t_token [2:0] tok;
    } t_bundle;

    function automatic t_token mk_tok(logic [3:0] kind, logic [POS_W-1:0] start,
                                      logic [POS_W-1:0] length);
        t_token t;
        t.kind   = kind;
        t.start  = start;
        t.length = length;
        return t;
    endfunction

    function automatic t_bundle add_tok(t_bundle b, t_token t);
        t_bundle r;
        r = b;
        r.tok[r.cnt] = t;
        r.cnt = r.cnt + 2'd1;
        return r;
    endfunction

endpackage

// ===== hw/rtl/boolean_query_lexer.sv =====
// Boolean query lexer, top level. Takes one query byte per cycle and emits
// tokens (kind, start offset, length) for terms, phrases, operators, brackets
// and the closing end or error token. The input side accepts a byte every cycle
// as long as the four-entry queue of per-byte token bundles has room; the output
// side delivers one token per cycle while the receiver is ready, so a byte
// that yields several tokens holds the output until all of them are out, and
// the output port sets the sustained rate whenever the text averages more than
// one token per byte. Each token passes through the bundle queue and the output
// register. Depends on bql_pkg, bql_front, bql_queue and bql_back.
module boolean_query_lexer import bql_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_query_byte,
    input  logic             i_end_of_query,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [3:0]       o_token_kind,
    output logic [POS_W-1:0] o_token_start,
    output logic [POS_W-1:0] o_token_length,
    output logic             o_last_in_run
);

    logic    push;
    t_bundle push_bundle;
    logic    full;
    logic    head_valid;
    t_bundle head;
    logic    pop;

    bql_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_query_byte   (i_query_byte),
        .i_end_of_query (i_end_of_query),
        .i_full         (full),
        .o_push         (push),
        .o_bundle       (push_bundle)
    );

    bql_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_bundle     (push_bundle),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    bql_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (head_valid),
        .i_head         (head),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_last_in_run  (o_last_in_run)
    );

endmodule

// ===== hw/rtl/bql_front.sv =====
// Front end: accepts query bytes, keeps the lexer state and classifies each byte
// into a bundle of up to three tokens. Depends on bql_pkg.
module bql_front import bql_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_query_byte,
    input  logic             i_end_of_query,
    input  logic             i_full,
    output logic             o_push,
    output t_bundle          o_bundle
);

    logic [1:0]       r_mode, n_mode;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_start, n_start;
    logic [23:0]      r_prefix, n_prefix;
    logic             r_ovf, n_ovf;
    t_bundle          bundle;
    logic             accept;

    function automatic t_token word_tok(logic [23:0] pf, logic [POS_W-1:0] st,
                                        logic [POS_W:0] end_pos);
        logic [POS_W:0] len;
        t_token         t;
        len = end_pos - {1'b0, st};
        if (len == (POS_W+1)'(3) && pf == WORD_AND) begin
            t = mk_tok(KIND_AND, '0, '0);
        end else if (len == (POS_W+1)'(2) && pf == WORD_OR) begin
            t = mk_tok(KIND_OR, '0, '0);
        end else if (len == (POS_W+1)'(3) && pf == WORD_NOT) begin
            t = mk_tok(KIND_NOT, '0, '0);
        end else begin
            t = mk_tok(KIND_TERM, st, len[POS_W-1:0]);
        end
        return t;
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (bundle.cnt != 2'd0);
    assign o_bundle = bundle;

    always_comb begin
        logic [1:0]       md;
        logic [POS_W-1:0] p;
        logic [7:0]       c;
        logic             stop;
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_start  = r_start;
        n_prefix = r_prefix;
        n_ovf    = r_ovf;
        bundle   = '0;
        p        = r_pos;
        c        = i_query_byte;
        stop     = is_blank(c) || c == CH_LPAREN || c == CH_RPAREN || c == CH_QUOTE;
        md       = r_mode;
        if (r_ovf) begin
            // drop everything until the final byte
            if (i_end_of_query) begin
                bundle   = add_tok(bundle, mk_tok(KIND_TOOLONG, '0, '0));
                n_mode   = MODE_IDLE;
                n_pos    = '0;
                n_start  = '0;
                n_prefix = '0;
                n_ovf    = 1'b0;
            end
        end else begin
            if (md == MODE_PHRASE) begin
                if (c == CH_QUOTE) begin
                    bundle = add_tok(bundle, mk_tok(KIND_PHRASE, n_start, p - n_start));
                    md     = MODE_IDLE;
                end
            end else begin
                if (md == MODE_WORD) begin
                    if (stop) begin
                        bundle = add_tok(bundle, word_tok(n_prefix, n_start, {1'b0, p}));
                        md     = MODE_IDLE;
                    end else begin
                        n_prefix = {n_prefix[15:0], c};
                    end
                end
                if (md == MODE_IDLE) begin
                    if (is_blank(c)) begin
                        md = MODE_IDLE;
                    end else if (c == CH_LPAREN) begin
                        bundle = add_tok(bundle, mk_tok(KIND_LPAREN, p, '0));
                    end else if (c == CH_RPAREN) begin
                        bundle = add_tok(bundle, mk_tok(KIND_RPAREN, p, '0));
                    end else if (c == CH_QUOTE) begin
                        md      = MODE_PHRASE;
                        n_start = p + POS_W'(1);
                    end else begin
                        md       = MODE_WORD;
                        n_start  = p;
                        n_prefix = {16'd0, c};
                    end
                end
            end
            n_mode = md;

            if (i_end_of_query) begin
                if (md == MODE_WORD) begin
                    bundle = add_tok(bundle,
                                     word_tok(n_prefix, n_start, {1'b0, p} + (POS_W+1)'(1)));
                end
                if (md == MODE_PHRASE) begin
                    bundle = add_tok(bundle, mk_tok(KIND_UNTERM, '0, '0));
                end else begin
                    bundle = add_tok(bundle, mk_tok(KIND_END, '0, '0));
                end
                n_mode   = MODE_IDLE;
                n_pos    = '0;
                n_start  = '0;
                n_prefix = '0;
                n_ovf    = 1'b0;
            end else if ({1'b0, p} + (POS_W+1)'(1) >= (POS_W+1)'(POS_LIMIT)) begin
                n_ovf = 1'b1;
            end else begin
                n_pos = p + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_pos    <= '0;
            r_start  <= '0;
            r_prefix <= '0;
            r_ovf    <= 1'b0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_start  <= n_start;
            r_prefix <= n_prefix;
            r_ovf    <= n_ovf;
        end
    end

endmodule

// ===== hw/rtl/bql_queue.sv =====
// Short queue of token bundles between the front end and the output side.
// Depends on bql_pkg for the bundle type and depth.
module bql_queue import bql_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    output logic    o_full,
    output logic    o_head_valid,
    output t_bundle o_head,
    input  logic    i_pop
);

    t_bundle           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_full       = (r_cnt == QCNT_W'(QDEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_comb begin
        n_wr  = do_push ? r_wr + QPTR_W'(1) : r_wr;
        n_rd  = do_pop ? r_rd + QPTR_W'(1) : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

endmodule

// ===== hw/rtl/bql_back.sv =====
// Output side: walks head-bundle tokens one per cycle, unless stalled, into the
// output register and marks the last one of each byte. Depends on bql_pkg.
module bql_back import bql_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_head_valid,
    input  t_bundle          i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [3:0]       o_token_kind,
    output logic [POS_W-1:0] o_token_start,
    output logic [POS_W-1:0] o_token_length,
    output logic             o_last_in_run
);

    logic [1:0] r_sub, n_sub;
    logic       r_valid, n_valid;
    t_token     r_tok;
    logic       r_last;
    logic       load;
    logic       sub_last;

    assign load     = i_head_valid && (!r_valid || i_ready);
    assign sub_last = (r_sub == i_head.cnt - 2'd1);
    assign o_pop    = load && sub_last;

    always_comb begin
        n_sub   = r_sub;
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
            n_sub   = sub_last ? 2'd0 : r_sub + 2'd1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_sub   <= n_sub;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok  <= i_head.tok[r_sub];
            r_last <= sub_last;
        end
    end

    assign o_valid        = r_valid;
    assign o_token_kind   = r_tok.kind;
    assign o_token_start  = r_tok.start;
    assign o_token_length = r_tok.length;
    assign o_last_in_run  = r_last;

endmodule

// ===== hw/rtl/bql_checker.sv =====
// Port-level checks for the boolean query lexer, bound to the top level.
// Depends on bql_pkg for token codes.
module bql_checker import bql_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_ready,
    input logic [3:0]       o_token_kind,
    input logic [POS_W-1:0] o_token_start,
    input logic [POS_W-1:0] o_token_length,
    input logic             o_last_in_run
);

    // Hold a stalled item
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_token_kind)
            && $stable(o_token_start) && $stable(o_token_length)
            && $stable(o_last_in_run))
        else $error("output item changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // Closing tokens end the run of their byte and carry no offsets
    a_closing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind == KIND_END || o_token_kind == KIND_UNTERM
            || o_token_kind == KIND_TOOLONG)
        |-> o_last_in_run && o_token_start == '0 && o_token_length == '0)
        else $error("bad closing token");

    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind == KIND_LPAREN || o_token_kind == KIND_RPAREN
            || o_token_kind == KIND_AND || o_token_kind == KIND_OR
            || o_token_kind == KIND_NOT)
        |-> o_token_length == '0)
        else $error("bracket or operator with nonzero length");

endmodule

bind boolean_query_lexer bql_checker u_bql_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_token_kind   (o_token_kind),
    .o_token_start  (o_token_start),
    .o_token_length (o_token_length),
    .o_last_in_run  (o_last_in_run)
);
